[rtl/core/hcl_pkg.sv]
// Shared types and constants for the HTTP content-length body extractor
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_SEEK   = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_BLANK  = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    localparam int HDR_LEN   = 16;
    localparam int BLANK_LEN = 4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    // "Content-Length: "
    localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    // CR LF CR LF
    localparam logic [7:0] BLANK_TEXT [BLANK_LEN] = '{
        8'h0D, 8'h0A, 8'h0D, 8'h0A
    };

    // one result produced by the parser for the current request
    typedef struct packed {
        logic        emit;
        logic [7:0]  body_byte;
        logic        last_byte;
        logic [31:0] declared_length;
    } result_t;

    // parser status seen by the top level
    typedef struct packed {
        phase_t phase;
        logic   length_zero;
    } status_t;

endpackage

`default_nettype wire

[rtl/core/hcl_parser.sv]
// Byte-wise header match, length parse, blank-line search and body counting
`timescale 1ns / 1ps
`default_nettype none

module hcl_parser #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       rx_byte,
    output hcl_pkg::result_t      result,
    output hcl_pkg::status_t      status
);

    localparam int HIDX_W = $clog2(hcl_pkg::HDR_LEN);
    localparam int BIDX_W = $clog2(hcl_pkg::BLANK_LEN);
    localparam int SUM_W  = LENGTH_WIDTH + 4;

    hcl_pkg::phase_t             phase_reg, phase_next;
    logic [HIDX_W-1:0]           hdr_idx_reg, hdr_idx_next;
    logic [BIDX_W-1:0]           blank_idx_reg, blank_idx_next;
    logic                        stopped_reg, stopped_next;
    logic [LENGTH_WIDTH-1:0]     acc_reg, acc_next;
    logic [LENGTH_WIDTH-1:0]     count_reg, count_next;

    logic [LENGTH_WIDTH-1:0]     count_inc;
    logic [SUM_W-1:0]            acc_wide;
    logic [SUM_W-1:0]            acc_sum;
    logic                        acc_ovf;
    logic                        is_digit;
    logic                        is_eol;
    logic                        last;
    logic [31:0]                 len32;

    // acc * 10 + digit, with overflow out of the length width
    assign acc_wide = {4'b0000, acc_reg};
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1)
                    + {{(SUM_W-4){1'b0}}, 4'(rx_byte - hcl_pkg::CHAR_0)};
    assign acc_ovf  = |acc_sum[SUM_W-1:LENGTH_WIDTH];

    assign is_digit  = (rx_byte inside {[hcl_pkg::CHAR_0:hcl_pkg::CHAR_9]});
    assign is_eol    = (rx_byte == hcl_pkg::CHAR_CR) || (rx_byte == hcl_pkg::CHAR_LF);
    assign count_inc = count_reg + LENGTH_WIDTH'(1);
    assign last      = (count_inc == acc_reg);

    // reported length is the low 32 bits of the parsed value
    generate
        if (LENGTH_WIDTH >= 32)
        begin : g_len_wide
            assign len32 = acc_reg[31:0];
        end
        else
        begin : g_len_narrow
            assign len32 = {{(32-LENGTH_WIDTH){1'b0}}, acc_reg};
        end
    endgenerate

    // next-state logic
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        blank_idx_next = blank_idx_reg;
        stopped_next   = stopped_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        case (phase_reg)
            hcl_pkg::PH_SEEK:
            begin
                if (rx_byte == hcl_pkg::HDR_TEXT[hdr_idx_reg])
                begin
                    if (hdr_idx_reg == HIDX_W'(hcl_pkg::HDR_LEN - 1))
                    begin
                        hdr_idx_next = '0;
                        acc_next     = '0;
                        stopped_next = 1'b0;
                        phase_next   = hcl_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + HIDX_W'(1);
                    end
                end
                else
                begin
                    hdr_idx_next = '0;
                end
            end
            hcl_pkg::PH_DIGITS:
            begin
                if (is_eol)
                begin
                    if (acc_reg == '0)
                    begin
                        phase_next     = hcl_pkg::PH_SEEK;
                        hdr_idx_next   = '0;
                        stopped_next   = 1'b0;
                        blank_idx_next = '0;
                        count_next     = '0;
                    end
                    else
                    begin
                        // terminator is the first blank-line character tested
                        phase_next     = hcl_pkg::PH_BLANK;
                        blank_idx_next = (rx_byte == hcl_pkg::BLANK_TEXT[0])
                                       ? BIDX_W'(1) : '0;
                    end
                end
                else if (!stopped_reg && is_digit)
                begin
                    acc_next = acc_ovf ? '1 : acc_sum[LENGTH_WIDTH-1:0];
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
            hcl_pkg::PH_BLANK:
            begin
                if (rx_byte == hcl_pkg::BLANK_TEXT[blank_idx_reg])
                begin
                    if (blank_idx_reg == BIDX_W'(hcl_pkg::BLANK_LEN - 1))
                    begin
                        blank_idx_next = '0;
                        count_next     = '0;
                        phase_next     = hcl_pkg::PH_BODY;
                    end
                    else
                    begin
                        blank_idx_next = blank_idx_reg + BIDX_W'(1);
                    end
                end
                else
                begin
                    blank_idx_next = '0;
                end
            end
            hcl_pkg::PH_BODY:
            begin
                if (last)
                begin
                    phase_next     = hcl_pkg::PH_SEEK;
                    hdr_idx_next   = '0;
                    stopped_next   = 1'b0;
                    acc_next       = '0;
                    blank_idx_next = '0;
                    count_next     = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next     = hcl_pkg::PH_SEEK;
                hdr_idx_next   = '0;
                stopped_next   = 1'b0;
                acc_next       = '0;
                blank_idx_next = '0;
                count_next     = '0;
            end
        endcase
    end

    // result for the current request
    always_comb
    begin
        result.emit            = (phase_reg == hcl_pkg::PH_BODY);
        result.body_byte       = rx_byte;
        result.last_byte       = last;
        result.declared_length = len32;
    end

    assign status.phase       = phase_reg;
    assign status.length_zero = (acc_reg == '0);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hcl_pkg::PH_SEEK;
            hdr_idx_reg   <= '0;
            blank_idx_reg <= '0;
            stopped_reg   <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            blank_idx_reg <= blank_idx_next;
            stopped_reg   <= stopped_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hcl_out_reg.sv]
// Output register holding one body byte result until it is taken
`timescale 1ns / 1ps
`default_nettype none

module hcl_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire hcl_pkg::result_t  result,
    input  wire logic              body_stall,
    output logic                   body_valid,
    output logic [7:0]             body_byte,
    output logic                   last_byte,
    output logic [31:0]            declared_length,
    output logic                   full_stall
);

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] len_reg;

    // valid flag: set on load, cleared when the request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!body_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= result.body_byte;
            last_reg <= result.last_byte;
            len_reg  <= result.declared_length;
        end
    end

    assign body_valid      = valid_reg;
    assign body_byte       = byte_reg;
    assign last_byte       = last_reg;
    assign declared_length = len_reg;
    // a new result may only land when the held one is leaving or absent
    assign full_stall      = valid_reg && body_stall;

endmodule

`default_nettype wire

[rtl/core/http_content_length_body_extractor.sv]
// Top level of the HTTP content-length body extractor
// Usage:
//   rx channel (rx_valid, rx_stall, rx_byte) carries the response stream,
//   one byte per request. A request is taken when rx_valid is high and
//   rx_stall is low.
//   body channel (body_valid, body_stall, body_byte, last_byte,
//   declared_length) carries one request per body byte. last_byte marks the
//   byte that completes the declared length; the block then searches for the
//   next "Content-Length: " header.
// Timing:
//   one byte per cycle unless a held body request stalls; each byte is
//   handled in the cycle it is taken by the single-pass parser, and a body
//   byte is on the body channel in the next cycle, from the output register.
// Reset:
//   rst_n clears the parser to the header search and empties the output.
// Stall:
//   while a body request is held and body_stall is high, rx_stall is high;
//   otherwise bytes keep flowing while the held request leaves.
`timescale 1ns / 1ps
`default_nettype none

module http_content_length_body_extractor #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             body_valid,
    input  wire logic        body_stall,
    output logic [7:0]       body_byte,
    output logic             last_byte,
    output logic [31:0]      declared_length
);

    hcl_pkg::result_t result;
    hcl_pkg::status_t status;
    logic             fire;
    logic             full_stall;

    assign fire     = rx_valid && !rx_stall;
    assign rx_stall = full_stall;

    // parser
    hcl_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (rx_byte),
        .result  (result),
        .status  (status)
    );

    // output register
    hcl_out_reg u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (fire && result.emit),
        .result          (result),
        .body_stall      (body_stall),
        .body_valid      (body_valid),
        .body_byte       (body_byte),
        .last_byte       (last_byte),
        .declared_length (declared_length),
        .full_stall      (full_stall)
    );

    // a body byte taken in the body phase is on the output next cycle
    a_body_out: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status.phase == hcl_pkg::PH_BODY) |=> body_valid)
        else $error("body byte not presented");

    // a new body request only follows a body-phase byte
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(body_valid) |-> $past(fire && status.phase == hcl_pkg::PH_BODY))
        else $error("body request without body byte");

    // the last byte ends the body and restarts the header search
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.emit && result.last_byte)
        |=> (status.phase == hcl_pkg::PH_SEEK && status.length_zero))
        else $error("parser did not restart after last byte");

    // the body phase is never entered with a zero length
    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        (status.phase == hcl_pkg::PH_BODY) |-> !status.length_zero)
        else $error("body phase with zero length");

endmodule

`default_nettype wire

[test/hcl_checker.sv]
// Body channel checker: predicts extracted body bytes from the rx stream and compares
`timescale 1ns / 1ps

module hcl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        body_valid,
    input  logic        body_stall,
    input  logic [7:0]  body_byte,
    input  logic        last_byte,
    input  logic [31:0] declared_length,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [31:0] LENGTH_MAX = 32'hFFFF_FFFF;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] length;
    } body_beat_t;

    body_beat_t  body_expected_q[$];
    body_beat_t  oldest_beat;

    // predicted parser state
    hcl_pkg::phase_t parse_phase;
    int unsigned hdr_idx;
    int unsigned blank_idx;
    logic        value_stopped;
    logic [31:0] value_acc;
    logic [31:0] body_seen;

    task clear_parser();
        parse_phase   = hcl_pkg::PH_SEEK;
        hdr_idx       = 0;
        value_stopped = 1'b0;
        value_acc     = '0;
        blank_idx     = 0;
        body_seen     = '0;
    endtask

    // blank line match, a mismatch drops back to zero without a retry
    task step_blank_line(input logic [7:0] c);
        if (c == hcl_pkg::BLANK_TEXT[blank_idx])
        begin
            if (blank_idx + 1 == hcl_pkg::BLANK_LEN)
            begin
                blank_idx   = 0;
                body_seen   = '0;
                parse_phase = hcl_pkg::PH_BODY;
            end
            else
                blank_idx++;
        end
        else
            blank_idx = 0;
    endtask

    task predict_byte(input logic [7:0] c);
        logic [31:0] digit;
        body_beat_t  beat;
        case (parse_phase)
            hcl_pkg::PH_SEEK:
            begin
                if (c == hcl_pkg::HDR_TEXT[hdr_idx])
                begin
                    if (hdr_idx + 1 == hcl_pkg::HDR_LEN)
                    begin
                        hdr_idx       = 0;
                        value_acc     = '0;
                        value_stopped = 1'b0;
                        parse_phase   = hcl_pkg::PH_DIGITS;
                    end
                    else
                        hdr_idx++;
                end
                else
                    hdr_idx = 0;
            end
            hcl_pkg::PH_DIGITS:
            begin
                if (c == hcl_pkg::CHAR_CR || c == hcl_pkg::CHAR_LF)
                begin
                    // zero length goes straight back to the header search
                    if (value_acc == '0)
                        clear_parser();
                    else
                    begin
                        blank_idx   = 0;
                        parse_phase = hcl_pkg::PH_BLANK;
                        step_blank_line(c);
                    end
                end
                else if (!value_stopped && c >= hcl_pkg::CHAR_0 && c <= hcl_pkg::CHAR_9)
                begin
                    digit = 32'(c - hcl_pkg::CHAR_0);
                    if (value_acc > (LENGTH_MAX - digit) / 10)
                        value_acc = LENGTH_MAX;
                    else
                        value_acc = value_acc * 10 + digit;
                end
                else
                    value_stopped = 1'b1;
            end
            hcl_pkg::PH_BLANK:
                step_blank_line(c);
            default:
            begin
                body_seen   = body_seen + 1;
                beat.data   = c;
                beat.last   = (body_seen == value_acc);
                beat.length = value_acc;
                body_expected_q.push_back(beat);
                if (beat.last)
                    clear_parser();
            end
        endcase
    endtask

    task report_fail(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t body channel: %s", $time, what);
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        clear_parser();
    end

    // compare the outgoing request first, it always belongs to an earlier byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            body_expected_q.delete();
        end
        else
        begin
            if (body_valid && !body_stall)
            begin
                if (body_expected_q.size() == 0)
                    report_fail($sformatf("unexpected byte %02h last %0b length %0d",
                                          body_byte, last_byte, declared_length));
                else
                begin
                    oldest_beat = body_expected_q.pop_front();
                    if (body_byte !== oldest_beat.data || last_byte !== oldest_beat.last ||
                        declared_length !== oldest_beat.length)
                        report_fail($sformatf(
                            "expected %02h/%0b/%0d got %02h/%0b/%0d",
                            oldest_beat.data, oldest_beat.last, oldest_beat.length,
                            body_byte, last_byte, declared_length));
                end
            end
            if (rx_valid && !rx_stall)
                predict_byte(rx_byte);
        end
        pending_count = body_expected_q.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top: feeds HTTP response streams to the extractor and reports the verdict
`timescale 1ns / 1ps

module tb_top;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_SLOW,
        FLOW_SINK_SLOW,
        FLOW_BOTH_SLOW
    } flow_mode_t;

    localparam int RANDOM_BYTES = 920;
    localparam int STUCK_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        body_valid;
    logic        body_stall;
    logic [7:0]  body_byte;
    logic        last_byte;
    logic [31:0] declared_length;
    int          fail_count;
    int          pending_count;

    flow_mode_t  flow_mode;
    bit          hold_go;
    bit          hold_done;
    logic [7:0]  stream_q[$];
    int          directed_count;
    int          random_end;
    int          stuck_cycles;

    http_content_length_body_extractor uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .body_valid      (body_valid),
        .body_stall      (body_stall),
        .body_byte       (body_byte),
        .last_byte       (last_byte),
        .declared_length (declared_length)
    );

    hcl_checker body_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .body_valid      (body_valid),
        .body_stall      (body_stall),
        .body_byte       (body_byte),
        .last_byte       (last_byte),
        .declared_length (declared_length),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    always #5 clk = ~clk;

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endtask

    task push_crlf();
        stream_q.push_back(hcl_pkg::CHAR_CR);
        stream_q.push_back(hcl_pkg::CHAR_LF);
    endtask

    task push_random(input int n);
        repeat (n)
            stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // header, value, optional padding lines, blank line, then body bytes
    task add_response(input string value_text, input int body_len, input int pad_lines,
                      input bit lf_term);
        push_text("Content-Length: ");
        push_text(value_text);
        if (lf_term)
            stream_q.push_back(hcl_pkg::CHAR_LF);
        else
            push_crlf();
        repeat (pad_lines)
        begin
            push_text("X-Pad: 1");
            push_crlf();
        end
        push_crlf();
        if (lf_term && pad_lines == 0)
            push_crlf();
        push_random(body_len);
    endtask

    task build_directed();
        // extreme body values
        add_response("4", 0, 0, 1'b0);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(hcl_pkg::CHAR_CR);
        stream_q.push_back(hcl_pkg::CHAR_LF);
        // second C breaks the match and is not retried
        push_text("CoContent-Length: 3");
        push_crlf();
        push_crlf();
        push_text("abc");
        add_response("1", 1, 0, 1'b0);
        // zero length restarts the search
        add_response("0", 0, 0, 1'b0);
        add_response("2", 2, 0, 1'b0);
        // no digit before the non-digit counts as zero
        add_response(" 7", 0, 0, 1'b0);
        // non-digit stops the value, later digits ignored
        add_response("12x5", 12, 0, 1'b0);
        // LF terminator with leading zeros
        add_response("0003", 3, 0, 1'b1);
        // header lines break the blank line match
        add_response("9", 9, 2, 1'b0);
        // CR LF CR then a broken CR, then a full blank line
        push_text("Content-Length: 1");
        push_crlf();
        stream_q.push_back(hcl_pkg::CHAR_CR);
        push_crlf();
        push_crlf();
        push_crlf();
        push_random(1);
        // misspelled header is ignored
        push_text("Content-Lenxth: 5");
        push_crlf();
        push_crlf();
        push_text("hello");
        add_response("40", 40, 1, 1'b1);
    endtask

    task add_random_response();
        int    pick;
        int    body_len;
        int    cut;
        string value_text;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            // well-formed response with random content
            push_random($urandom_range(0, 4));
            body_len = chance(10) ? $urandom_range(41, 120) : $urandom_range(1, 24);
            value_text = $sformatf("%0d", body_len);
            if (chance(15))
                value_text = {"0", value_text};
            if (chance(10))
                value_text = {value_text, "z7"};
            add_response(value_text, body_len, $urandom_range(0, 2), chance(25));
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // truncated header
                    cut = $urandom_range(1, hcl_pkg::HDR_LEN - 1);
                    for (int i = 0; i < cut; i++)
                        stream_q.push_back(hcl_pkg::HDR_TEXT[i]);
                    stream_q.push_back("X");
                end
                1:
                    add_response(chance(50) ? string'("0") : string'("-"), 0,
                                 $urandom_range(0, 1), chance(50));
                default:
                begin
                    // blank line never completed here
                    push_text("Content-Length: ");
                    push_text($sformatf("%0d", $urandom_range(1, 9)));
                    push_crlf();
                    push_text("X-Cut");
                end
            endcase
        end
        else
            push_random($urandom_range(1, 16));
    endtask

    task send_byte(input logic [7:0] b);
        while (chance(flow_mode == FLOW_SRC_SLOW ? 83 : flow_mode == FLOW_BOTH_SLOW ? 12 : 0))
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        @(negedge clk);
    endtask

    // receiver side: one long hold-off, then random stalls per flow mode
    initial
    begin
        body_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                repeat (HOLD_CYCLES)
                begin
                    body_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            body_stall <= chance(flow_mode == FLOW_SINK_SLOW ? 83 :
                                 flow_mode == FLOW_BOTH_SLOW ? 12 : 0);
        end
    end

    // watchdog on cycles with no request moving on either channel
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (rx_valid && !rx_stall) || (body_valid && !body_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        rx_valid  = 1'b0;
        rx_byte   = 8'h00;
        flow_mode = FLOW_FREE;

        build_directed();
        directed_count = stream_q.size();
        while (stream_q.size() - directed_count < RANDOM_BYTES)
            add_random_response();
        random_end = stream_q.size();
        // saturated length goes last, its body can never complete
        add_response("4294967296", 6, 0, 1'b0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < stream_q.size(); i++)
        begin
            if (i == directed_count)
                hold_go = 1'b1;
            if (i >= directed_count && i < random_end)
                flow_mode = flow_mode_t'((i - directed_count) * 4
                                         / (random_end - directed_count));
            send_byte(stream_q[i]);
        end
        rx_valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
